// File: hdl/j3e_pkg.sv
// Shared types, constants and elaboration-time CORDIC tables for the 3x3
// symmetric Jacobi eigenvalue block. No dependencies.
package j3e_pkg;

  localparam int MAX_SWEEPS   = 12;
  localparam int CORDIC_STEPS = 32;
  localparam int MUL_N        = 12;

  localparam int IN_W    = 32;
  localparam int OUT_W   = 34;
  localparam int VAL_W   = 48;
  localparam int SUM_W   = 52;
  localparam int PROD_W  = 49;
  localparam int Q30_W   = 32;
  localparam int CORD_W  = 64;
  localparam int TOL_W   = 16;

  localparam int SWEEP_W = $clog2(MAX_SWEEPS + 1);
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int MUL_W   = $clog2(MUL_N);
  localparam int IDX_W   = STEP_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_PICK = 4'd2;
  localparam logic [3:0] OP_NORM = 4'd3;
  localparam logic [3:0] OP_QUAD = 4'd4;
  localparam logic [3:0] OP_VEC  = 4'd5;
  localparam logic [3:0] OP_ROTI = 4'd6;
  localparam logic [3:0] OP_ROT  = 4'd7;
  localparam logic [3:0] OP_CS   = 4'd8;
  localparam logic [3:0] OP_MLO  = 4'd9;
  localparam logic [3:0] OP_MHI  = 4'd10;
  localparam logic [3:0] OP_MFIN = 4'd11;
  localparam logic [3:0] OP_UPD  = 4'd12;
  localparam logic [3:0] OP_OUT  = 4'd13;

  typedef struct packed {
    logic [3:0]       op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic below_tol;
    logic vec_zero;
    logic norm_done;
  } status_t;

  typedef logic [CORDIC_STEPS-1:0][CORD_W-1:0] atan_rom_t;

  // Restoring division, used only while the constant tables are built.
  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Alternating series for atan(1/n) in Q60, every division truncating.
  function automatic logic signed [63:0] atan_series(input logic [63:0] n);
    logic [63:0]        p;
    logic [63:0]        term;
    logic signed [63:0] sum;
    p   = const_udiv(64'd1 << 60, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = const_udiv(p, 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
        p = const_udiv(const_udiv(p, n), n);
      end
    end
    return sum;
  endfunction

  function automatic atan_rom_t build_atan_rom();
    atan_rom_t rom;
    rom[0] = 4 * atan_series(64'd5) - atan_series(64'd239);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      rom[i] = atan_series(64'd1 << i);
    end
    return rom;
  endfunction

  localparam atan_rom_t ATAN_ROM = build_atan_rom();

  function automatic logic signed [63:0] build_pi();
    logic signed [63:0] a0;
    a0 = $signed(ATAN_ROM[0]);
    return a0 <<< 2;
  endfunction

  localparam logic signed [CORD_W-1:0] PI_Q60 = build_pi();

  // Reciprocal of the CORDIC gain in Q60.
  function automatic logic signed [63:0] build_kinv();
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [63:0]        g;
    logic [63:0]        r;
    logic [63:0]        q;
    x = 64'sd1 <<< 61;
    y = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    g = x;
    r = 64'd1 << 61;
    q = '0;
    for (int i = 0; i < 60; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= g) begin
        r = r - g;
        q = q | 64'd1;
      end
    end
    return $signed(q);
  endfunction

  localparam logic signed [CORD_W-1:0] KINV_Q60 = build_kinv();

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] res;
    if (v[SUM_W-1:VAL_W-1] == '0 || v[SUM_W-1:VAL_W-1] == '1) begin
      res = v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VAL_W-1:0] v);
    logic signed [OUT_W-1:0] res;
    if (v[VAL_W-1:OUT_W-1] == '0 || v[VAL_W-1:OUT_W-1] == '1) begin
      res = v[OUT_W-1:0];
    end else if (v[VAL_W-1]) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// File: hdl/j3e_ctrl.sv
// Sequencing state machine for the Jacobi eigenvalue block: issues one
// datapath operation at most once a cycle and runs the handshakes. Depends on j3e_pkg.
module j3e_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  j3e_pkg::status_t status,
  output j3e_pkg::cmd_t    cmd
);
  import j3e_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PICK = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_QUAD = 4'd3;
  localparam logic [3:0] S_VEC  = 4'd4;
  localparam logic [3:0] S_ROTI = 4'd5;
  localparam logic [3:0] S_ROT  = 4'd6;
  localparam logic [3:0] S_CS   = 4'd7;
  localparam logic [3:0] S_MLO  = 4'd8;
  localparam logic [3:0] S_MHI  = 4'd9;
  localparam logic [3:0] S_MFIN = 4'd10;
  localparam logic [3:0] S_UPD  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic [MUL_W-1:0]   mcnt;
  logic [MUL_W-1:0]   mcnt_next;
  logic [SWEEP_W-1:0] sweep;
  logic [SWEEP_W-1:0] sweep_next;
  logic               out_fire;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    mcnt_next  = mcnt;
    sweep_next = sweep;
    out_fire   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.idx    = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          sweep_next = '0;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (status.below_tol || sweep == SWEEP_W'(MAX_SWEEPS)) begin
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_PICK;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        // A zero vector has angle zero and skips straight to rotation.
        if (status.vec_zero) begin
          state_next = S_ROTI;
        end else if (status.norm_done) begin
          state_next = S_QUAD;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_QUAD: begin
        cmd.op     = OP_QUAD;
        step_next  = '0;
        state_next = S_VEC;
      end
      S_VEC: begin
        cmd.op    = OP_VEC;
        cmd.idx   = IDX_W'(step);
        step_next = step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = S_ROTI;
        end
      end
      S_ROTI: begin
        cmd.op     = OP_ROTI;
        step_next  = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op    = OP_ROT;
        cmd.idx   = IDX_W'(step);
        step_next = step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = S_CS;
        end
      end
      S_CS: begin
        cmd.op     = OP_CS;
        mcnt_next  = '0;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.op     = OP_MLO;
        cmd.idx    = IDX_W'(mcnt);
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.op     = OP_MHI;
        cmd.idx    = IDX_W'(mcnt);
        state_next = S_MFIN;
      end
      S_MFIN: begin
        cmd.op    = OP_MFIN;
        cmd.idx   = IDX_W'(mcnt);
        mcnt_next = mcnt + 1'b1;
        if (mcnt == MUL_W'(MUL_N - 1)) begin
          state_next = S_UPD;
        end else begin
          state_next = S_MLO;
        end
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        sweep_next = sweep + 1'b1;
        state_next = S_PICK;
      end
      S_OUT: begin
        // The output register is written only once the previous result is gone.
        if (!out_valid || !out_stall) begin
          cmd.op     = OP_OUT;
          out_fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      mcnt      <= '0;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      mcnt      <= mcnt_next;
      sweep     <= sweep_next;
      out_valid <= (out_valid && out_stall) || out_fire;
    end
  end

endmodule

// File: hdl/j3e_datapath.sv
// Datapath of the Jacobi eigenvalue block: tensor registers, pivot search,
// shared CORDIC step, split multiplier, update and sort. Depends on j3e_pkg.
module j3e_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  j3e_pkg::cmd_t                          cmd,
  output j3e_pkg::status_t                       status,
  input  logic                                   cfg_write,
  input  logic        [j3e_pkg::TOL_W-1:0]       cfg_data,
  input  logic signed [j3e_pkg::IN_W-1:0]        stress_xx,
  input  logic signed [j3e_pkg::IN_W-1:0]        stress_yy,
  input  logic signed [j3e_pkg::IN_W-1:0]        stress_zz,
  input  logic signed [j3e_pkg::IN_W-1:0]        shear_xy,
  input  logic signed [j3e_pkg::IN_W-1:0]        shear_yz,
  input  logic signed [j3e_pkg::IN_W-1:0]        shear_xz,
  output logic signed [j3e_pkg::OUT_W-1:0]       principal_max,
  output logic signed [j3e_pkg::OUT_W-1:0]       principal_mid,
  output logic signed [j3e_pkg::OUT_W-1:0]       principal_min
);
  import j3e_pkg::*;

  localparam logic [1:0] PAIR_01 = 2'd0;
  localparam logic [1:0] PAIR_02 = 2'd1;
  localparam logic [1:0] PAIR_12 = 2'd2;

  localparam logic [MUL_W-1:0] MUL_CC = 4'd0;
  localparam logic [MUL_W-1:0] MUL_SS = 4'd1;
  localparam logic [MUL_W-1:0] MUL_SC = 4'd2;
  localparam logic [MUL_W-1:0] MUL_T1 = 4'd3;
  localparam logic [MUL_W-1:0] MUL_T2 = 4'd4;
  localparam logic [MUL_W-1:0] MUL_T3 = 4'd5;
  localparam logic [MUL_W-1:0] MUL_T4 = 4'd6;
  localparam logic [MUL_W-1:0] MUL_T5 = 4'd7;
  localparam logic [MUL_W-1:0] MUL_T6 = 4'd8;
  localparam logic [MUL_W-1:0] MUL_T7 = 4'd9;
  localparam logic [MUL_W-1:0] MUL_T8 = 4'd10;
  localparam logic [MUL_W-1:0] MUL_T9 = 4'd11;

  localparam int HALF_W = VAL_W / 2;
  localparam int UK_W   = Q30_W - 1;
  localparam int PP_W   = HALF_W + UK_W;
  localparam int ACC_W  = PP_W + HALF_W + 1;

  logic [TOL_W-1:0] tol;

  logic signed [VAL_W-1:0] a00, a11, a22, a01, a02, a12;

  // Pivot search.
  logic [VAL_W-1:0]        m01, m02, m12, mx;
  logic [1:0]              piv;
  logic signed [VAL_W-1:0] piv_app, piv_apq, piv_aqq, piv_arp, piv_arq;

  logic [1:0]              pair;
  logic signed [VAL_W-1:0] app, apq, aqq, arp, arq;

  // CORDIC registers and one step.
  logic signed [CORD_W-1:0] x, y, z;
  logic [CORD_W-1:0]        xm, ym;
  logic signed [CORD_W-1:0] dx, dy, ang, xr;
  logic signed [VAL_W:0]    diff;

  logic signed [Q30_W-1:0] c, s;

  // Multiplier.
  logic signed [PROD_W-1:0] prod [MUL_N];
  logic signed [VAL_W-1:0]  mul_a;
  logic signed [Q30_W-1:0]  mul_k;
  logic [VAL_W-1:0]         ua;
  logic [Q30_W-1:0]         uk_full;
  logic [UK_W-1:0]          uk;
  logic                     neg;
  logic [PP_W-1:0]          plo, phi;
  logic [ACC_W-1:0]         acc;
  logic [PROD_W-1:0]        mres;
  logic signed [PROD_W-1:0] mres_s;

  // Update.
  logic signed [SUM_W-1:0] app2, aqq2, arp2, arq2;

  // Sort.
  logic signed [VAL_W-1:0] v0, v1, v2, tv;

  always_comb begin
    m01 = a01[VAL_W-1] ? (~a01 + 1'b1) : a01;
    m02 = a02[VAL_W-1] ? (~a02 + 1'b1) : a02;
    m12 = a12[VAL_W-1] ? (~a12 + 1'b1) : a12;
    piv = PAIR_01;
    mx  = m01;
    if (m02 > mx) begin
      piv = PAIR_02;
      mx  = m02;
    end
    if (m12 > mx) begin
      piv = PAIR_12;
      mx  = m12;
    end
    case (piv)
      PAIR_02: begin
        piv_app = a00; piv_apq = a02; piv_aqq = a22; piv_arp = a01; piv_arq = a12;
      end
      PAIR_12: begin
        piv_app = a11; piv_apq = a12; piv_aqq = a22; piv_arp = a01; piv_arq = a02;
      end
      default: begin
        piv_app = a00; piv_apq = a01; piv_aqq = a11; piv_arp = a02; piv_arq = a12;
      end
    endcase
    diff = {piv_aqq[VAL_W-1], piv_aqq} - {piv_app[VAL_W-1], piv_app};
  end

  always_comb begin
    xm  = x[CORD_W-1] ? (~x + 1'b1) : x;
    ym  = y[CORD_W-1] ? (~y + 1'b1) : y;
    dx  = y >>> cmd.idx;
    dy  = x >>> cmd.idx;
    ang = $signed(ATAN_ROM[cmd.idx]);
    xr  = (x + (64'sd1 <<< 29)) >>> 30;
    status.below_tol = (mx <= {{(VAL_W-TOL_W){1'b0}}, tol});
    status.vec_zero  = (x == '0) && (y == '0);
    status.norm_done = (xm[CORD_W-1:56] != '0) || (ym[CORD_W-1:56] != '0);
  end

  always_comb begin
    case (cmd.idx[MUL_W-1:0])
      MUL_CC: begin mul_a = VAL_W'(c);  mul_k = c; end
      MUL_SS: begin mul_a = VAL_W'(s);  mul_k = s; end
      MUL_SC: begin mul_a = VAL_W'(c);  mul_k = s; end
      MUL_T1: begin mul_a = app; mul_k = prod[MUL_CC][Q30_W-1:0]; end
      MUL_T2: begin mul_a = apq; mul_k = prod[MUL_SC][Q30_W-1:0]; end
      MUL_T3: begin mul_a = aqq; mul_k = prod[MUL_SS][Q30_W-1:0]; end
      MUL_T4: begin mul_a = app; mul_k = prod[MUL_SS][Q30_W-1:0]; end
      MUL_T5: begin mul_a = aqq; mul_k = prod[MUL_CC][Q30_W-1:0]; end
      MUL_T6: begin mul_a = arp; mul_k = c; end
      MUL_T7: begin mul_a = arq; mul_k = s; end
      MUL_T8: begin mul_a = arp; mul_k = s; end
      MUL_T9: begin mul_a = arq; mul_k = c; end
      default: begin mul_a = '0; mul_k = '0; end
    endcase
    ua      = mul_a[VAL_W-1] ? (~mul_a + 1'b1) : mul_a;
    uk_full = mul_k[Q30_W-1] ? (~mul_k + 1'b1) : mul_k;
    uk      = uk_full[UK_W-1:0];
    neg     = mul_a[VAL_W-1] ^ mul_k[Q30_W-1];
    // Magnitude product rounded half up, then the sign is applied.
    acc     = {phi, {HALF_W{1'b0}}} + ACC_W'(plo) + (ACC_W'(1) << 29);
    mres    = acc[PROD_W+29:30];
    mres_s  = neg ? $signed(~mres + 1'b1) : $signed(mres);
  end

  always_comb begin
    app2 = SUM_W'(prod[MUL_T1]) - (SUM_W'(prod[MUL_T2]) <<< 1) + SUM_W'(prod[MUL_T3]);
    aqq2 = SUM_W'(prod[MUL_T4]) + (SUM_W'(prod[MUL_T2]) <<< 1) + SUM_W'(prod[MUL_T5]);
    arp2 = SUM_W'(prod[MUL_T6]) - SUM_W'(prod[MUL_T7]);
    arq2 = SUM_W'(prod[MUL_T8]) + SUM_W'(prod[MUL_T9]);
  end

  always_comb begin
    v0 = a00;
    v1 = a11;
    v2 = a22;
    tv = '0;
    if (v0 < v1) begin tv = v0; v0 = v1; v1 = tv; end
    if (v1 < v2) begin tv = v1; v1 = v2; v2 = tv; end
    if (v0 < v1) begin tv = v0; v0 = v1; v1 = tv; end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_write) begin
      tol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a00 <= VAL_W'(stress_xx);
        a11 <= VAL_W'(stress_yy);
        a22 <= VAL_W'(stress_zz);
        a01 <= VAL_W'(shear_xy);
        a12 <= VAL_W'(shear_yz);
        a02 <= VAL_W'(shear_xz);
      end
      OP_PICK: begin
        pair <= piv;
        app  <= piv_app;
        apq  <= piv_apq;
        aqq  <= piv_aqq;
        arp  <= piv_arp;
        arq  <= piv_arq;
        x    <= CORD_W'(diff);
        y    <= CORD_W'(piv_apq) <<< 1;
        z    <= '0;
      end
      OP_NORM: begin
        // Eight doublings at once while both stay well clear of the limit.
        if (xm[CORD_W-1:48] == '0 && ym[CORD_W-1:48] == '0) begin
          x <= x <<< 8;
          y <= y <<< 8;
        end else begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      OP_QUAD: begin
        if (x[CORD_W-1]) begin
          z <= y[CORD_W-1] ? -PI_Q60 : PI_Q60;
          x <= -x;
          y <= -y;
        end
      end
      OP_VEC: begin
        if (y > 0) begin
          x <= x + dx; y <= y - dy; z <= z + ang;
        end else begin
          x <= x - dx; y <= y + dy; z <= z - ang;
        end
      end
      OP_ROTI: begin
        x <= KINV_Q60;
        y <= '0;
        z <= z >>> 1;
      end
      OP_ROT: begin
        if (!z[CORD_W-1]) begin
          x <= x - dx; y <= y + dy; z <= z - ang;
        end else begin
          x <= x + dx; y <= y - dy; z <= z + ang;
        end
      end
      OP_CS: begin
        if (xr > (64'sd1 <<< 30)) begin
          c <= Q30_W'(32'sd1 <<< 30);
        end else if (xr < -(64'sd1 <<< 30)) begin
          c <= -(32'sd1 <<< 30);
        end else begin
          c <= xr[Q30_W-1:0];
        end
        if (((y + (64'sd1 <<< 29)) >>> 30) > (64'sd1 <<< 30)) begin
          s <= Q30_W'(32'sd1 <<< 30);
        end else if (((y + (64'sd1 <<< 29)) >>> 30) < -(64'sd1 <<< 30)) begin
          s <= -(32'sd1 <<< 30);
        end else begin
          s <= Q30_W'((y + (64'sd1 <<< 29)) >>> 30);
        end
      end
      OP_MLO: begin
        plo <= PP_W'(ua[HALF_W-1:0] * uk);
      end
      OP_MHI: begin
        phi <= PP_W'(ua[VAL_W-1:HALF_W] * uk);
      end
      OP_MFIN: begin
        prod[cmd.idx[MUL_W-1:0]] <= mres_s;
      end
      OP_UPD: begin
        case (pair)
          PAIR_02: begin
            a00 <= sat_val(app2);
            a22 <= sat_val(aqq2);
            a01 <= sat_val(arp2);
            a12 <= sat_val(arq2);
            a02 <= '0;
          end
          PAIR_12: begin
            a11 <= sat_val(app2);
            a22 <= sat_val(aqq2);
            a01 <= sat_val(arp2);
            a02 <= sat_val(arq2);
            a12 <= '0;
          end
          default: begin
            a00 <= sat_val(app2);
            a11 <= sat_val(aqq2);
            a02 <= sat_val(arp2);
            a12 <= sat_val(arq2);
            a01 <= '0;
          end
        endcase
      end
      OP_OUT: begin
        principal_max <= sat_out(v0);
        principal_mid <= sat_out(v1);
        principal_min <= sat_out(v2);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/symmetric3_jacobi_eigenvalues.sv
// Principal values of a symmetric 3x3 stress tensor by cyclic-max Jacobi sweeps.
// Each sweep runs two 32-step passes of the shared CORDIC stage, normalising
// shifts and twelve split multiplies, each in a low, a high and a final step;
// at most 12 sweeps are run before the result is loaded.
// One item at a time: the next input can be taken in the cycle after the result is loaded.
// Reset (synchronous, active high) clears the sequencer and sets the tolerance to 1.
// Depends on j3e_pkg, j3e_ctrl and j3e_datapath.
module symmetric3_jacobi_eigenvalues (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic        [j3e_pkg::TOL_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [j3e_pkg::IN_W-1:0]  stress_xx,
  input  logic signed [j3e_pkg::IN_W-1:0]  stress_yy,
  input  logic signed [j3e_pkg::IN_W-1:0]  stress_zz,
  input  logic signed [j3e_pkg::IN_W-1:0]  shear_xy,
  input  logic signed [j3e_pkg::IN_W-1:0]  shear_yz,
  input  logic signed [j3e_pkg::IN_W-1:0]  shear_xz,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [j3e_pkg::OUT_W-1:0] principal_max,
  output logic signed [j3e_pkg::OUT_W-1:0] principal_mid,
  output logic signed [j3e_pkg::OUT_W-1:0] principal_min
);
  import j3e_pkg::*;

  cmd_t    cmd;
  status_t status;

  j3e_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  j3e_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .stress_xx     (stress_xx),
    .stress_yy     (stress_yy),
    .stress_zz     (stress_zz),
    .shear_xy      (shear_xy),
    .shear_yz      (shear_yz),
    .shear_xz      (shear_xz),
    .principal_max (principal_max),
    .principal_mid (principal_mid),
    .principal_min (principal_min)
  );

endmodule
